[rtl/reliable_reorder_ack_engine_core_assert.svh]
// Assertion macros for the reorder and acknowledgement engine.
// Used by the checker module; depends on nothing else.
`ifndef RELIABLE_REORDER_ACK_ENGINE_CORE_ASSERT_SVH
`define RELIABLE_REORDER_ACK_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RRAE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrae: same-cycle property violated");

// Next-cycle implication, disabled while reset is high.
`define RRAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrae: next-cycle property violated");

`endif

[rtl/rrae_pkg.sv]
// Shared types, codes and sizing constants for the reorder and acknowledgement engine.
// Used by every module of the block but rrae_ram; depends on nothing.
package rrae_pkg;

   localparam int WINDOW           = 32;
   localparam int HANDLE_BITS      = 16;
   localparam int HANDLE_PORT_BITS = 16;
   localparam int HANDLE_W         = (HANDLE_BITS < HANDLE_PORT_BITS) ? HANDLE_BITS
                                                                     : HANDLE_PORT_BITS;
   localparam int SLOT_BITS        = $clog2(WINDOW);
   localparam int SEQ_BITS         = 32;
   localparam int CHANNEL_BITS     = 8;
   localparam int CMD_BITS         = 2;
   localparam int MSG_BITS         = 2;
   localparam int ACK_BITS_W       = 32;
   localparam int ACK_LOW_BITS     = $clog2(ACK_BITS_W);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_BITS        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_ADDR_BITS    = SLOT_BITS + 1;
   localparam int RAM_DEPTH        = 2 ** RAM_ADDR_BITS;

   localparam logic [SLOT_BITS:0]   WINDOW_WIDE = (SLOT_BITS + 1)'(WINDOW);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT   = SLOT_BITS'(WINDOW - 1);
   localparam logic [SLOT_BITS-1:0] DRAIN_LIMIT = SLOT_BITS'(WINDOW - 2);
   localparam logic [SEQ_BITS-1:0]  WINDOW_SEQ  = SEQ_BITS'(WINDOW);

   // Packet kinds on the request side.
   localparam logic [CMD_BITS-1:0] CMD_RELIABLE   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_UNRELIABLE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_ORDERED    = 2'd2;

   // Result kinds and delivered message kinds.
   localparam logic KIND_DELIVERY = 1'b0;
   localparam logic KIND_ACK      = 1'b1;

   localparam logic [MSG_BITS-1:0] MSG_RELIABLE   = 2'd0;
   localparam logic [MSG_BITS-1:0] MSG_UNRELIABLE = 2'd1;
   localparam logic [MSG_BITS-1:0] MSG_ORDERED    = 2'd2;

   localparam logic STREAM_RELIABLE = 1'b0;
   localparam logic STREAM_ORDERED  = 1'b1;

   typedef enum logic [1:0] {
      OP_RELIABLE,
      OP_UNRELIABLE,
      OP_ORDERED
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DRAIN,
      ST_ACK
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic [CHANNEL_BITS-1:0] channel;
      logic [SEQ_BITS-1:0]     seq;
      logic [HANDLE_W-1:0]     handle;
   } item_type;

endpackage

[rtl/rrae_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the buffered payload handles; depends on nothing.
module rrae_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rrae_front.sv]
// Front end: takes packet headers, classifies them and queues them for the back end.
// Depends on rrae_pkg.
module rrae_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rrae_pkg::CMD_BITS-1:0]     req_command,
   input  logic [rrae_pkg::CHANNEL_BITS-1:0] req_channel,
   input  logic [rrae_pkg::SEQ_BITS-1:0]     req_seq,
   input  logic [rrae_pkg::HANDLE_PORT_BITS-1:0] req_payload_handle,
   output logic                              busy,
   output logic                              q_valid,
   output rrae_pkg::item_type                q_item,
   input  logic                              q_pop
);
   import rrae_pkg::*;

   item_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   item_type               new_item;
   logic                   keep;
   logic                   push;
   logic                   pop;

   // Headers of the unused fourth kind are taken and dropped here.
   always_comb begin
      new_item.channel = req_channel;
      new_item.seq     = req_seq;
      new_item.handle  = req_payload_handle[HANDLE_W-1:0];
      case (req_command)
         CMD_RELIABLE: begin
            new_item.op = OP_RELIABLE;
            keep        = 1'b1;
         end
         CMD_UNRELIABLE: begin
            new_item.op = OP_UNRELIABLE;
            keep        = 1'b1;
         end
         CMD_ORDERED: begin
            new_item.op = OP_ORDERED;
            keep        = 1'b1;
         end
         default: begin
            new_item.op = OP_RELIABLE;
            keep        = 1'b0;
         end
      endcase
   end

   assign busy    = (count_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = queue_ff[rd_ptr_ff];
   assign push    = start && !busy && keep;
   assign pop     = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/rrae_back.sv]
// Back end: window test, slot storage, in-order drain and acknowledgement results.
// Depends on rrae_pkg and rrae_ram.
module rrae_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  rrae_pkg::item_type                    q_item,
   output logic                                  q_pop,
   output logic                                  rsp_strobe,
   output logic                                  rsp_kind,
   output logic [rrae_pkg::MSG_BITS-1:0]         rsp_msg_type,
   output logic [rrae_pkg::CHANNEL_BITS-1:0]     rsp_out_channel,
   output logic [rrae_pkg::HANDLE_PORT_BITS-1:0] rsp_out_handle,
   output logic [rrae_pkg::SEQ_BITS-1:0]         rsp_ack_seq,
   output logic [rrae_pkg::ACK_BITS_W-1:0]       rsp_ack_bits,
   output logic                                  rsp_last
);
   import rrae_pkg::*;

   state_type                      state_ff, state_in;
   item_type                       item_ff, item_in;
   logic [1:0][SEQ_BITS-1:0]       expected_ff, expected_in;
   logic [1:0][SLOT_BITS-1:0]      eidx_ff, eidx_in;
   logic [1:0][WINDOW-1:0]         valid_ff, valid_in;
   logic [SLOT_BITS-1:0]           cnt_ff, cnt_in;

   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [MSG_BITS-1:0]            rsp_msg_type_ff, rsp_msg_type_in;
   logic [CHANNEL_BITS-1:0]        rsp_out_channel_ff, rsp_out_channel_in;
   logic [HANDLE_PORT_BITS-1:0]    rsp_out_handle_ff, rsp_out_handle_in;
   logic [SEQ_BITS-1:0]            rsp_ack_seq_ff, rsp_ack_seq_in;
   logic [ACK_BITS_W-1:0]          rsp_ack_bits_ff, rsp_ack_bits_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           str;
   logic [SEQ_BITS-1:0]            exp_cur;
   logic [SLOT_BITS-1:0]           idx_cur;
   logic [SEQ_BITS-1:0]            seq_gap;
   logic                           borrow;
   logic                           is_next;
   logic                           in_win;
   logic [SLOT_BITS-1:0]           store_idx;
   logic [SLOT_BITS-1:0]           inc_idx;
   logic                           next_valid;
   logic                           drain_more;
   logic [ACK_BITS_W-1:0]          ack_bits_w;
   logic [MSG_BITS-1:0]            stream_msg;

   logic                           ram_we;
   logic [RAM_ADDR_BITS-1:0]       ram_waddr;
   logic                           ram_re;
   logic [RAM_ADDR_BITS-1:0]       ram_raddr;
   logic [HANDLE_W-1:0]            ram_rdata;

   // Adds two slot numbers modulo the window size.
   function automatic logic [SLOT_BITS-1:0] slot_add(input logic [SLOT_BITS-1:0] a,
                                                     input logic [SLOT_BITS-1:0] b);
      logic [SLOT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= WINDOW_WIDE) begin
         sum = sum - WINDOW_WIDE;
      end
      return sum[SLOT_BITS-1:0];
   endfunction

   // Slot of expected + 1; the counter wrapping to zero restarts the slot numbering.
   function automatic logic [SLOT_BITS-1:0] next_index(input logic [SEQ_BITS-1:0] expv,
                                                       input logic [SLOT_BITS-1:0] idx);
      logic [SLOT_BITS-1:0] res;
      if (expv == '1) begin
         res = '0;
      end else if (idx == LAST_SLOT) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   assign str        = (item_ff.op == OP_ORDERED) ? STREAM_ORDERED : STREAM_RELIABLE;
   assign exp_cur    = expected_ff[str];
   assign idx_cur    = eidx_ff[str];
   assign {borrow, seq_gap} = {1'b0, item_ff.seq} - {1'b0, exp_cur};
   assign is_next    = (seq_gap == '0);
   assign in_win     = !is_next && (seq_gap < WINDOW_SEQ);
   // When seq lies past the 32-bit wrap it is smaller than the window and is its own slot.
   assign store_idx  = borrow ? item_ff.seq[SLOT_BITS-1:0]
                              : slot_add(idx_cur, seq_gap[SLOT_BITS-1:0]);
   assign inc_idx    = next_index(exp_cur, idx_cur);
   assign next_valid = valid_ff[str][inc_idx];
   assign drain_more = (cnt_ff < DRAIN_LIMIT) && next_valid && (inc_idx != idx_cur);
   assign stream_msg = (str == STREAM_ORDERED) ? MSG_ORDERED : MSG_RELIABLE;

   // Selective acknowledgement bitmap over the reliable window; bit zero is never set.
   always_comb begin
      logic [ACK_LOW_BITS:0] lane_sum;
      logic                  lane_wrap;
      logic [SLOT_BITS-1:0]  lane_idx;
      ack_bits_w = '0;
      for (int i = 1; i < WINDOW; i++) begin
         lane_sum  = {1'b0, expected_ff[STREAM_RELIABLE][ACK_LOW_BITS-1:0]}
                     + (ACK_LOW_BITS + 1)'(i);
         lane_wrap = (&expected_ff[STREAM_RELIABLE][SEQ_BITS-1:ACK_LOW_BITS])
                     && lane_sum[ACK_LOW_BITS];
         lane_idx  = lane_wrap ? lane_sum[SLOT_BITS-1:0]
                               : slot_add(eidx_ff[STREAM_RELIABLE], SLOT_BITS'(i));
         ack_bits_w[i] = valid_ff[STREAM_RELIABLE][lane_idx];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (item_ff.op == OP_UNRELIABLE) begin
               state_in = ST_IDLE;
            end else if (is_next && next_valid) begin
               state_in = ST_DRAIN;
            end else if (item_ff.op == OP_RELIABLE) begin
               state_in = ST_ACK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (drain_more) begin
               state_in = ST_DRAIN;
            end else if (item_ff.op == OP_RELIABLE) begin
               state_in = ST_ACK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop              = 1'b0;
      item_in            = item_ff;
      expected_in        = expected_ff;
      eidx_in            = eidx_ff;
      valid_in           = valid_ff;
      cnt_in             = cnt_ff;
      ram_we             = 1'b0;
      ram_waddr          = {str, store_idx};
      ram_re             = 1'b0;
      ram_raddr          = {str, inc_idx};
      rsp_strobe_in      = 1'b0;
      rsp_kind_in        = KIND_DELIVERY;
      rsp_msg_type_in    = MSG_RELIABLE;
      rsp_out_channel_in = '0;
      rsp_out_handle_in  = '0;
      rsp_ack_seq_in     = '0;
      rsp_ack_bits_in    = '0;
      rsp_last_in        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               item_in = q_item;
            end
         end
         ST_EVAL: begin
            case (item_ff.op)
               OP_UNRELIABLE: begin
                  rsp_strobe_in      = 1'b1;
                  rsp_msg_type_in    = MSG_UNRELIABLE;
                  rsp_out_channel_in = item_ff.channel;
                  rsp_out_handle_in  = HANDLE_PORT_BITS'(item_ff.handle);
                  rsp_last_in        = 1'b1;
               end
               OP_RELIABLE, OP_ORDERED: begin
                  if (is_next) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_msg_type_in    = stream_msg;
                     rsp_out_channel_in = item_ff.channel;
                     rsp_out_handle_in  = HANDLE_PORT_BITS'(item_ff.handle);
                     rsp_last_in        = (str == STREAM_ORDERED) && !next_valid;
                     expected_in[str]   = exp_cur + 1'b1;
                     eidx_in[str]       = inc_idx;
                     cnt_in             = '0;
                     ram_re             = next_valid;
                  end else if (in_win) begin
                     valid_in[str][store_idx] = 1'b1;
                     ram_we                   = 1'b1;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b0;
               end
            endcase
         end
         ST_DRAIN: begin
            rsp_strobe_in          = 1'b1;
            rsp_msg_type_in        = stream_msg;
            rsp_out_channel_in     = item_ff.channel;
            rsp_out_handle_in      = HANDLE_PORT_BITS'(ram_rdata);
            rsp_last_in            = (str == STREAM_ORDERED) && !drain_more;
            valid_in[str][idx_cur] = 1'b0;
            expected_in[str]       = exp_cur + 1'b1;
            eidx_in[str]           = inc_idx;
            cnt_in                 = cnt_ff + 1'b1;
            ram_re                 = drain_more;
         end
         ST_ACK: begin
            rsp_strobe_in   = 1'b1;
            rsp_kind_in     = KIND_ACK;
            rsp_ack_seq_in  = expected_ff[STREAM_RELIABLE] - 1'b1;
            rsp_ack_bits_in = ack_bits_w;
            rsp_last_in     = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= '0;
         eidx_ff       <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         eidx_ff       <= eidx_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff            <= item_in;
      rsp_kind_ff        <= rsp_kind_in;
      rsp_msg_type_ff    <= rsp_msg_type_in;
      rsp_out_channel_ff <= rsp_out_channel_in;
      rsp_out_handle_ff  <= rsp_out_handle_in;
      rsp_ack_seq_ff     <= rsp_ack_seq_in;
      rsp_ack_bits_ff    <= rsp_ack_bits_in;
      rsp_last_ff        <= rsp_last_in;
   end

   rrae_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (item_ff.handle),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_msg_type    = rsp_msg_type_ff;
   assign rsp_out_channel = rsp_out_channel_ff;
   assign rsp_out_handle  = rsp_out_handle_ff;
   assign rsp_ack_seq     = rsp_ack_seq_ff;
   assign rsp_ack_bits    = rsp_ack_bits_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[rtl/reliable_reorder_ack_engine_core.sv]
// Top level of the packet reorder and selective acknowledgement engine.
// Depends on rrae_pkg, rrae_front and rrae_back.
//
//   Channel   Ports                       Handshake
//   request   req_*  (command .. handle)  taken when start is high and busy is low
//   response  rsp_*  (kind .. last)       each result marked by rsp_strobe
//
// The front end queues up to two headers; busy is high while that queue is full.
// The back end takes a header and evaluates it, then drains each buffered handle from
// the handle RAM (one read per cycle, up to WINDOW-1), then sends the acknowledgement
// of a reliable packet, and only then takes the next header.
// Results of one header come out on consecutive cycles, the last one flagged.
// Reset is synchronous and clears the sequence counters and slot valid bits at once.
module reliable_reorder_ack_engine_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [rrae_pkg::CMD_BITS-1:0]         req_command,
   input  logic [rrae_pkg::CHANNEL_BITS-1:0]     req_channel,
   input  logic [rrae_pkg::SEQ_BITS-1:0]         req_seq,
   input  logic [rrae_pkg::HANDLE_PORT_BITS-1:0] req_payload_handle,
   output logic                                  busy,
   output logic                                  rsp_strobe,
   output logic                                  rsp_kind,
   output logic [rrae_pkg::MSG_BITS-1:0]         rsp_msg_type,
   output logic [rrae_pkg::CHANNEL_BITS-1:0]     rsp_out_channel,
   output logic [rrae_pkg::HANDLE_PORT_BITS-1:0] rsp_out_handle,
   output logic [rrae_pkg::SEQ_BITS-1:0]         rsp_ack_seq,
   output logic [rrae_pkg::ACK_BITS_W-1:0]       rsp_ack_bits,
   output logic                                  rsp_last
);
   import rrae_pkg::*;

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   rrae_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_command        (req_command),
      .req_channel        (req_channel),
      .req_seq            (req_seq),
      .req_payload_handle (req_payload_handle),
      .busy               (busy),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   rrae_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_msg_type    (rsp_msg_type),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_ack_seq     (rsp_ack_seq),
      .rsp_ack_bits    (rsp_ack_bits),
      .rsp_last        (rsp_last)
   );

endmodule

[rtl/rrae_checker.sv]
// Port-level assertions for the reorder engine, bound to the top level.
// Depends on rrae_pkg and the assertion macro header.
`include "reliable_reorder_ack_engine_core_assert.svh"

module rrae_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_strobe,
   input logic                                  rsp_kind,
   input logic [rrae_pkg::MSG_BITS-1:0]         rsp_msg_type,
   input logic [rrae_pkg::CHANNEL_BITS-1:0]     rsp_out_channel,
   input logic [rrae_pkg::HANDLE_PORT_BITS-1:0] rsp_out_handle,
   input logic [rrae_pkg::SEQ_BITS-1:0]         rsp_ack_seq,
   input logic [rrae_pkg::ACK_BITS_W-1:0]       rsp_ack_bits,
   input logic                                  rsp_last
);
   import rrae_pkg::*;

   // An acknowledgement always closes its burst and never marks the expected slot.
   `RRAE_ASSERT_IMPLIES(a_ack_closes, clock, reset, rsp_strobe && (rsp_kind == KIND_ACK), rsp_last && (rsp_msg_type == MSG_RELIABLE) && (rsp_out_channel == '0) && (rsp_out_handle == '0) && !rsp_ack_bits[0])
   `RRAE_ASSERT_IMPLIES(a_delivery_clean, clock, reset, rsp_strobe && (rsp_kind == KIND_DELIVERY), (rsp_ack_seq == '0) && (rsp_ack_bits == '0) && (rsp_msg_type <= MSG_ORDERED))
   `RRAE_ASSERT_IMPLIES(a_unreliable_single, clock, reset, rsp_strobe && (rsp_msg_type == MSG_UNRELIABLE), rsp_last && (rsp_kind == KIND_DELIVERY))
   // Results of one header are back to back, and a burst is followed by a quiet cycle.
   `RRAE_ASSERT_NEXT(a_burst_contiguous, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)
   `RRAE_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_last, !rsp_strobe)

endmodule

bind reliable_reorder_ack_engine_core rrae_checker u_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the packet reorder and selective acknowledgement engine.
// Depends on rrae_pkg and reliable_reorder_ack_engine_core; holds its own reorder predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rrae_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 230;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 4 * WINDOW + 20;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CMD_BITS-1:0]         CMD_RESERVED = 2'd3;
   localparam logic [HANDLE_PORT_BITS-1:0] HANDLE_MASK  =
      HANDLE_PORT_BITS'((64'd1 << HANDLE_W) - 1);

   typedef struct packed {
      logic [CMD_BITS-1:0]         command;
      logic [CHANNEL_BITS-1:0]     channel;
      logic [SEQ_BITS-1:0]         seq;
      logic [HANDLE_PORT_BITS-1:0] handle;
   } pkt_hdr_type;

   typedef struct packed {
      logic                        kind;
      logic [MSG_BITS-1:0]         msg_type;
      logic [CHANNEL_BITS-1:0]     channel;
      logic [HANDLE_PORT_BITS-1:0] handle;
      logic [SEQ_BITS-1:0]         ack_seq;
      logic [ACK_BITS_W-1:0]       ack_bits;
      logic                        last;
   } engine_out_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic [CMD_BITS-1:0]         req_command = '0;
   logic [CHANNEL_BITS-1:0]     req_channel = '0;
   logic [SEQ_BITS-1:0]         req_seq = '0;
   logic [HANDLE_PORT_BITS-1:0] req_payload_handle = '0;
   logic                        busy;
   logic                        rsp_strobe;
   logic                        rsp_kind;
   logic [MSG_BITS-1:0]         rsp_msg_type;
   logic [CHANNEL_BITS-1:0]     rsp_out_channel;
   logic [HANDLE_PORT_BITS-1:0] rsp_out_handle;
   logic [SEQ_BITS-1:0]         rsp_ack_seq;
   logic [ACK_BITS_W-1:0]       rsp_ack_bits;
   logic                        rsp_last;

   // Predictor state, indexed by STREAM_RELIABLE and STREAM_ORDERED.
   logic [SEQ_BITS-1:0]         next_seq    [0:1];
   logic                        slot_valid  [0:1][0:WINDOW-1];
   logic [HANDLE_PORT_BITS-1:0] slot_handle [0:1][0:WINDOW-1];

   pkt_hdr_type    pending_headers[$];
   engine_out_type awaited_results[$];

   int   errors = 0;
   int   headers_taken = 0;
   int   total_headers = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   logic timed_out = 1'b0;

   reliable_reorder_ack_engine_core u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_command        (req_command),
      .req_channel        (req_channel),
      .req_seq            (req_seq),
      .req_payload_handle (req_payload_handle),
      .busy               (busy),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_ack_seq        (rsp_ack_seq),
      .rsp_ack_bits       (rsp_ack_bits),
      .rsp_last           (rsp_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic note_error(input string what);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, what);
      end
   endtask

   function automatic engine_out_type delivery(input logic [MSG_BITS-1:0] msg,
                                               input logic [CHANNEL_BITS-1:0] ch,
                                               input logic [HANDLE_PORT_BITS-1:0] handle);
      engine_out_type o;
      o          = '0;
      o.kind     = KIND_DELIVERY;
      o.msg_type = msg;
      o.channel  = ch;
      o.handle   = handle & HANDLE_MASK;
      return o;
   endfunction

   // Delivers the expected packet and drains its buffered successors, or stores an
   // early packet in its slot; anything else is dropped.
   function automatic void stream_advance(input logic stream,
                                          input logic [MSG_BITS-1:0] msg,
                                          input pkt_hdr_type hdr,
                                          ref engine_out_type outs[$]);
      logic [SEQ_BITS-1:0] seq_gap;
      int                  slot;
      seq_gap = hdr.seq - next_seq[stream];
      if (seq_gap == '0) begin
         outs.insert(outs.size(), delivery(msg, hdr.channel, hdr.handle));
         next_seq[stream] = next_seq[stream] + 1;
         for (int i = 0; i < WINDOW - 1; i++) begin
            slot = int'(next_seq[stream] % WINDOW_SEQ);
            if (!slot_valid[stream][slot]) break;
            // Drained items carry the channel of the packet that has just arrived.
            outs.insert(outs.size(), delivery(msg, hdr.channel, slot_handle[stream][slot]));
            slot_valid[stream][slot] = 1'b0;
            next_seq[stream] = next_seq[stream] + 1;
         end
      end else if (seq_gap < WINDOW_SEQ) begin
         slot = int'(hdr.seq % WINDOW_SEQ);
         slot_valid[stream][slot]  = 1'b1;
         slot_handle[stream][slot] = hdr.handle & HANDLE_MASK;
      end
   endfunction

   function automatic void predict_header(input pkt_hdr_type hdr);
      engine_out_type outs[$];
      engine_out_type ack;
      if (hdr.command == CMD_UNRELIABLE) begin
         outs.insert(outs.size(), delivery(MSG_UNRELIABLE, hdr.channel, hdr.handle));
      end else if (hdr.command == CMD_ORDERED) begin
         stream_advance(STREAM_ORDERED, MSG_ORDERED, hdr, outs);
      end else if (hdr.command == CMD_RELIABLE) begin
         stream_advance(STREAM_RELIABLE, MSG_RELIABLE, hdr, outs);
         ack         = '0;
         ack.kind    = KIND_ACK;
         ack.ack_seq = next_seq[STREAM_RELIABLE] - 1;
         for (int i = 1; i < ACK_BITS_W && i < WINDOW; i++) begin
            if (slot_valid[STREAM_RELIABLE][int'((next_seq[STREAM_RELIABLE] + i) % WINDOW_SEQ)])
               ack.ack_bits[i] = 1'b1;
         end
         outs.insert(outs.size(), ack);
      end
      if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[k]) awaited_results.insert(awaited_results.size(), outs[k]);
   endfunction

   task automatic queue_header(input logic [CMD_BITS-1:0] command,
                               input logic [CHANNEL_BITS-1:0] channel,
                               input logic [SEQ_BITS-1:0] seq,
                               input logic [HANDLE_PORT_BITS-1:0] handle);
      pkt_hdr_type hdr;
      hdr = '{command, channel, seq, handle};
      pending_headers.insert(pending_headers.size(), hdr);
   endtask

   // Plans a run of consecutive sequence numbers from base in shuffled order. A full
   // window run keeps the base packet for last so that it drains every slot.
   function automatic void plan_run(ref logic [SEQ_BITS-1:0] run[$],
                                    ref logic [SEQ_BITS-1:0] base);
      int                  len;
      int                  j;
      logic                full;
      logic [SEQ_BITS-1:0] tmp;
      run.delete();
      full = ($urandom_range(0, 7) == 0);
      len  = full ? WINDOW : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) run.insert(run.size(), base + i);
      for (int i = len - 1; i > 0; i--) begin
         j      = $urandom_range(0, i);
         tmp    = run[i];
         run[i] = run[j];
         run[j] = tmp;
      end
      if (full) begin
         foreach (run[k]) begin
            if (run[k] == base) begin
               run[k]       = run[len - 1];
               run[len - 1] = base;
            end
         end
      end else if ($urandom_range(0, 3) == 0) begin
         run.insert($urandom_range(0, len), run[$urandom_range(0, len - 1)]);
      end
      base = base + len;
   endfunction

   // Sender: bursts of items separated by random gaps, holding an item while busy.
   always @(posedge clock) begin
      logic        take_next;
      pkt_hdr_type hdr;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_header('{req_command, req_channel, req_seq, req_payload_handle});
            headers_taken++;
         end
         if (!(start && busy)) begin
            take_next = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_headers.size() != 0) begin
               take_next = 1'b1;
               hdr = pending_headers.pop_front();
               req_command        <= hdr.command;
               req_channel        <= hdr.channel;
               req_seq            <= hdr.seq;
               req_payload_handle <= hdr.handle;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 23);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1, 2:    gap_left = $urandom_range(1, 4);
                     default: gap_left = $urandom_range(5, 40);
                  endcase
               end
            end
            start <= take_next;
         end
      end
   end

   // Receiver: every strobed result is compared with the oldest awaited one.
   always @(posedge clock) begin
      engine_out_type seen;
      engine_out_type want;
      if (!reset && rsp_strobe) begin
         seen = '{rsp_kind, rsp_msg_type, rsp_out_channel, rsp_out_handle,
                  rsp_ack_seq, rsp_ack_bits, rsp_last};
         if (awaited_results.size() == 0) begin
            note_error($sformatf("unexpected result: kind %0d msg %0d chan %0h handle %0h",
                                 seen.kind, seen.msg_type, seen.channel, seen.handle));
         end else begin
            want = awaited_results.pop_front();
            if (seen !== want) begin
               note_error($sformatf({"result mismatch (expected/actual): kind %0d/%0d ",
                                     "msg %0d/%0d chan %0h/%0h handle %0h/%0h ",
                                     "ack_seq %0h/%0h ack_bits %0h/%0h last %0d/%0d"},
                                    want.kind, seen.kind, want.msg_type, seen.msg_type,
                                    want.channel, seen.channel, want.handle, seen.handle,
                                    want.ack_seq, seen.ack_seq, want.ack_bits, seen.ack_bits,
                                    want.last, seen.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         timed_out <= 1'b1;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      pkt_hdr_type         hdr;
      logic [SEQ_BITS-1:0] rel_run[$];
      logic [SEQ_BITS-1:0] ord_run[$];
      logic [SEQ_BITS-1:0] rel_base;
      logic [SEQ_BITS-1:0] ord_base;
      logic [SEQ_BITS-1:0] stray_base;
      int                  counted;
      int                  pick;

      for (int s = 0; s < 2; s++) begin
         next_seq[s] = '0;
         for (int k = 0; k < WINDOW; k++) begin
            slot_valid[s][k]  = 1'b0;
            slot_handle[s][k] = '0;
         end
      end

      queue_header(CMD_UNRELIABLE, 8'h00, 32'h0000_0000, 16'h0000);
      queue_header(CMD_UNRELIABLE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
      queue_header(CMD_RELIABLE,   8'h01, 32'd0, 16'hFFFF);
      queue_header(CMD_RELIABLE,   8'hFF, 32'd2, 16'h1111);
      // A duplicate must overwrite the stored handle.
      queue_header(CMD_RELIABLE,   8'h02, 32'd2, 16'h2222);
      queue_header(CMD_RELIABLE,   8'h03, 32'd3, 16'h3333);
      // Last sequence inside the window, then the first one beyond it.
      queue_header(CMD_RELIABLE,   8'h04, WINDOW, 16'h0000);
      queue_header(CMD_RELIABLE,   8'h05, WINDOW + 1, 16'h5555);
      queue_header(CMD_RELIABLE,   8'h06, 32'd0, 16'h6666);
      queue_header(CMD_RELIABLE,   8'h07, 32'hFFFF_FFFF, 16'h7777);
      queue_header(CMD_RELIABLE,   8'hA5, 32'd1, 16'h8001);
      queue_header(CMD_ORDERED,    8'h10, 32'd5, 16'h0505);
      queue_header(CMD_ORDERED,    8'h11, 32'd0, 16'hFFFF);
      queue_header(CMD_ORDERED,    8'h12, 32'd3, 16'h0303);
      queue_header(CMD_ORDERED,    8'hFF, 32'd1, 16'h0101);
      queue_header(CMD_ORDERED,    8'h00, 32'd2, 16'h0202);
      queue_header(CMD_ORDERED,    8'h5A, 32'd4, 16'h0404);
      queue_header(CMD_ORDERED,    8'h13, 6 + WINDOW - 1, 16'hBEEF);
      queue_header(CMD_ORDERED,    8'h14, 6 + WINDOW, 16'hDEAD);
      queue_header(CMD_ORDERED,    8'h15, 32'd0, 16'h1234);
      queue_header(CMD_ORDERED,    8'h16, 32'hFFFF_FFFF, 16'h4321);
      queue_header(CMD_RESERVED,   8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
      queue_header(CMD_RESERVED,   8'h00, 32'd0, 16'h0000);

      // Streams stand at sequence 4 (reliable) and 6 (ordered) after the directed part.
      rel_base = 4;
      ord_base = 6;
      counted  = 0;
      while (counted < RANDOM_ITEMS) begin
         pick        = $urandom_range(0, 99);
         hdr.channel = $urandom;
         hdr.handle  = $urandom;
         hdr.seq     = $urandom;
         if (pick < 43) begin
            if (rel_run.size() == 0) plan_run(rel_run, rel_base);
            hdr.command = CMD_RELIABLE;
            hdr.seq     = rel_run.pop_front();
         end else if (pick < 80) begin
            if (ord_run.size() == 0) plan_run(ord_run, ord_base);
            hdr.command = CMD_ORDERED;
            hdr.seq     = ord_run.pop_front();
         end else if (pick < 86) begin
            hdr.command = CMD_UNRELIABLE;
         end else if (pick < 89) begin
            hdr.command = CMD_RESERVED;
         end else begin
            // Stray packets: stale, beyond the window, or anywhere at all.
            hdr.command = $urandom_range(0, 1) ? CMD_RELIABLE : CMD_ORDERED;
            stray_base  = (hdr.command == CMD_RELIABLE) ? rel_base : ord_base;
            case ($urandom_range(0, 2))
               0:       hdr.seq = stray_base - 1 - $urandom_range(0, 40);
               1:       hdr.seq = stray_base + WINDOW + $urandom_range(0, 1000);
               default: hdr.seq = $urandom;
            endcase
         end
         pending_headers.insert(pending_headers.size(), hdr);
         if (hdr.command != CMD_RESERVED) counted++;
      end
      total_headers = pending_headers.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (headers_taken < total_headers && !timed_out) @(posedge clock);
      while (awaited_results.size() != 0 && !timed_out) @(posedge clock);
      if (!timed_out) repeat (SETTLE_CYCLES) @(posedge clock);
      if (timed_out) note_error("watchdog expired with no handshake progress");
      if (awaited_results.size() != 0)
         note_error($sformatf("%0d expected results never arrived", awaited_results.size()));

      if (!timed_out && errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
